// ===== hdl/kfe_pkg.sv =====
// Shared types and KISS byte codes for the KISS frame encoder.
`timescale 1ns / 1ps
`default_nettype none

package kfe_pkg;

    localparam logic [7:0] KISS_DELIM     = 8'hC0;
    localparam logic [7:0] KISS_ESC       = 8'hDB;
    localparam logic [7:0] KISS_ESC_DELIM = 8'hDC;
    localparam logic [7:0] KISS_ESC_ESC   = 8'hDD;
    localparam logic [7:0] KISS_CMD_DATA  = 8'h00;
    localparam logic [15:0] MIN_CAPACITY  = 16'd4;

    typedef struct packed {
        logic [7:0] payload_byte;
        logic       first_of_frame;
        logic       last_of_frame;
        logic       empty_frame;
    } kfe_in_t;

    typedef struct packed {
        logic [7:0] out_byte;
        logic       end_of_output;
        logic       frame_done;
        logic       overflow_error;
    } kfe_out_t;

    // What the payload part of one input transaction turns into
    typedef enum logic [1:0] {
        BODY_NONE  = 2'd0,
        BODY_PLAIN = 2'd1,
        BODY_ESC   = 2'd2,
        BODY_ERR   = 2'd3
    } kfe_body_t;

    // One queue entry: the result sequence of one input transaction
    typedef struct packed {
        logic       hdr;
        kfe_body_t  body;
        logic [7:0] data;
        logic       trl;
        logic [2:0] count;
    } kfe_desc_t;

endpackage

`default_nettype wire

// ===== hdl/kfe_front.sv =====
// Front end: holds frame state and capacity, classifies each input transaction.
`timescale 1ns / 1ps
`default_nettype none

module kfe_front
    import kfe_pkg::*;
(
    input  wire logic       clk,
    input  wire logic       rst_n,
    input  wire logic       item_valid,
    input  wire kfe_in_t    item,
    output logic            item_stall,
    input  wire logic       capacity_we,
    input  wire logic [15:0] capacity_wdata,
    input  wire logic       queue_full,
    output logic            push,
    output kfe_desc_t       desc
);

    logic [15:0] capacity_reg;
    logic [15:0] count_reg, count_next;
    logic        open_reg, open_next;
    logic        accept;
    logic [16:0] need;
    logic        stuff;
    logic [2:0]  body_n;

    assign item_stall = queue_full;
    assign accept     = item_valid && !queue_full;

    always_comb
    begin
        count_next = count_reg;
        open_next  = open_reg;
        desc.hdr   = 1'b0;
        desc.body  = BODY_NONE;
        desc.data  = item.payload_byte;
        desc.trl   = 1'b0;
        stuff      = (item.payload_byte == KISS_DELIM) || (item.payload_byte == KISS_ESC);
        need       = 17'd0;
        body_n     = 3'd0;

        if (item.first_of_frame)
        begin
            count_next = 16'd0;
            open_next  = 1'b0;
            if (capacity_reg < MIN_CAPACITY)
            begin
                desc.body = BODY_ERR;
            end
            else
            begin
                desc.hdr   = 1'b1;
                count_next = 16'd2;
                open_next  = 1'b1;
            end
        end

        if (open_next && !item.empty_frame)
        begin
            need = {1'b0, count_next} + (stuff ? 17'd3 : 17'd2);
            if (need >= {1'b0, capacity_reg})
            begin
                // abandon the frame without a closing delimiter
                desc.body  = BODY_ERR;
                open_next  = 1'b0;
                count_next = 16'd0;
            end
            else if (stuff)
            begin
                desc.body  = BODY_ESC;
                count_next = count_next + 16'd2;
            end
            else
            begin
                desc.body  = BODY_PLAIN;
                count_next = count_next + 16'd1;
            end
        end

        if (open_next && item.last_of_frame)
        begin
            desc.trl   = 1'b1;
            count_next = count_next + 16'd1;
            open_next  = 1'b0;
        end

        case (desc.body)
            BODY_NONE:  body_n = 3'd0;
            BODY_PLAIN: body_n = 3'd1;
            BODY_ESC:   body_n = 3'd2;
            BODY_ERR:   body_n = 3'd1;
            default:    body_n = 3'd0;
        endcase
        desc.count = (desc.hdr ? 3'd2 : 3'd0) + body_n + {2'b00, desc.trl};
    end

    // transactions that give no result are taken but never queued
    assign push = accept && (desc.count != 3'd0);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            capacity_reg <= 16'hFFFF;
            count_reg    <= 16'd0;
            open_reg     <= 1'b0;
        end
        else
        begin
            if (capacity_we)
            begin
                capacity_reg <= capacity_wdata;
            end
            if (accept)
            begin
                count_reg <= count_next;
                open_reg  <= open_next;
            end
        end
    end

endmodule

`default_nettype wire

// ===== hdl/kfe_fifo.sv =====
// Short descriptor queue between front and back end.
`timescale 1ns / 1ps
`default_nettype none

module kfe_fifo
    import kfe_pkg::*;
#(
    parameter int DEPTH = 4
)
(
    input  wire logic      clk,
    input  wire logic      rst_n,
    input  wire logic      push,
    input  wire kfe_desc_t wr_data,
    input  wire logic      pop,
    output kfe_desc_t      rd_data,
    output logic           full,
    output logic           not_empty
);

    localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W = $clog2(DEPTH + 1);
    localparam logic [PTR_W-1:0] LAST_PTR = PTR_W'(DEPTH - 1);
    localparam logic [CNT_W-1:0] FULL_CNT = CNT_W'(DEPTH);

    kfe_desc_t        mem_reg [DEPTH];
    logic [PTR_W-1:0] wr_ptr_reg, rd_ptr_reg;
    logic [CNT_W-1:0] cnt_reg;

    assign full      = (cnt_reg == FULL_CNT);
    assign not_empty = (cnt_reg != '0);
    assign rd_data   = mem_reg[rd_ptr_reg];

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            mem_reg[wr_ptr_reg] <= wr_data;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            cnt_reg    <= '0;
        end
        else
        begin
            if (push)
            begin
                wr_ptr_reg <= (wr_ptr_reg == LAST_PTR) ? '0 : wr_ptr_reg + 1'b1;
            end
            if (pop)
            begin
                rd_ptr_reg <= (rd_ptr_reg == LAST_PTR) ? '0 : rd_ptr_reg + 1'b1;
            end
            if (push && !pop)
            begin
                cnt_reg <= cnt_reg + 1'b1;
            end
            else if (pop && !push)
            begin
                cnt_reg <= cnt_reg - 1'b1;
            end
        end
    end

endmodule

`default_nettype wire

// ===== hdl/kfe_back.sv =====
// Back end: expands queued descriptors into output bytes, one per cycle while result_stall is low.
`timescale 1ns / 1ps
`default_nettype none

module kfe_back
    import kfe_pkg::*;
(
    input  wire logic      clk,
    input  wire logic      rst_n,
    input  wire logic      desc_valid,
    input  wire kfe_desc_t desc,
    output logic           pop,
    output logic           result_valid,
    input  wire logic      result_stall,
    output kfe_out_t       result
);

    logic [2:0] step_reg;
    logic       valid_reg;
    kfe_out_t   result_reg;
    kfe_out_t   slot;
    logic       load;
    logic       last_step;
    logic [2:0] hdr_n;
    logic [2:0] body_n;
    logic [2:0] q;

    always_comb
    begin
        hdr_n  = desc.hdr ? 3'd2 : 3'd0;
        body_n = (desc.body == BODY_ESC) ? 3'd2 :
                 (desc.body == BODY_NONE) ? 3'd0 : 3'd1;
        q      = step_reg - hdr_n;
        slot   = '0;
        if (step_reg < hdr_n)
        begin
            slot.out_byte = (step_reg == 3'd0) ? KISS_DELIM : KISS_CMD_DATA;
        end
        else if (q < body_n)
        begin
            case (desc.body)
                BODY_PLAIN: slot.out_byte = desc.data;
                BODY_ESC:
                begin
                    if (q == 3'd0)
                    begin
                        slot.out_byte = KISS_ESC;
                    end
                    else
                    begin
                        slot.out_byte = (desc.data == KISS_DELIM) ? KISS_ESC_DELIM
                                                                  : KISS_ESC_ESC;
                    end
                end
                BODY_ERR:
                begin
                    slot.frame_done     = 1'b1;
                    slot.overflow_error = 1'b1;
                end
                default:    slot.out_byte = 8'h00;
            endcase
        end
        else
        begin
            // closing delimiter
            slot.out_byte   = KISS_DELIM;
            slot.frame_done = 1'b1;
        end
        last_step          = (step_reg == desc.count - 3'd1);
        slot.end_of_output = last_step;
    end

    assign load = desc_valid && (!valid_reg || !result_stall);
    assign pop  = load && last_step;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            step_reg  <= 3'd0;
            valid_reg <= 1'b0;
        end
        else
        begin
            if (load)
            begin
                valid_reg <= 1'b1;
                step_reg  <= last_step ? 3'd0 : step_reg + 3'd1;
            end
            else if (!result_stall)
            begin
                valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (load)
        begin
            result_reg <= slot;
        end
    end

    assign result_valid = valid_reg;
    assign result       = result_reg;

endmodule

`default_nettype wire

// ===== hdl/kiss_frame_encoder.sv =====
// KISS data frame encoder with byte stuffing and buffer capacity check.
//
// Input channel (item_valid / item_stall / item): one payload byte per
// transaction, marked first, last or empty. Output channel (result_valid /
// result_stall / result): one encoded frame byte per transaction, with
// end-of-output, frame-done and overflow flags.
// capacity_we / capacity_wdata load the frame capacity register (reset 65535).
// The front end classifies a transaction in the cycle it is taken and pushes
// a descriptor into a QUEUE_DEPTH entry queue; the back end expands it into
// 1 to 5 results at one result per cycle while result_stall is low, and
// registers each result. Sustained rate is one output byte per cycle when
// not stalled; an input transaction gives one result for a plain byte, two
// for a stuffed one, plus two for the header and one for the trailer;
// transactions that give no result are taken but not queued.
// item_stall rises only when the queue is full, i.e. when the back end falls
// behind, either held by result_stall or busy with multi-result transactions.
// Reset closes any open frame, empties the queue and drops the pending result.
`timescale 1ns / 1ps
`default_nettype none

module kiss_frame_encoder
    import kfe_pkg::*;
#(
    parameter int QUEUE_DEPTH = 4
)
(
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        item_valid,
    output logic             item_stall,
    input  wire kfe_in_t     item,
    output logic             result_valid,
    input  wire logic        result_stall,
    output kfe_out_t         result,
    input  wire logic        capacity_we,
    input  wire logic [15:0] capacity_wdata
);

    logic      push;
    logic      pop;
    logic      queue_full;
    logic      queue_valid;
    kfe_desc_t front_desc;
    kfe_desc_t head_desc;

    kfe_front u_front (
        .clk            (clk),
        .rst_n          (rst_n),
        .item_valid     (item_valid),
        .item           (item),
        .item_stall     (item_stall),
        .capacity_we    (capacity_we),
        .capacity_wdata (capacity_wdata),
        .queue_full     (queue_full),
        .push           (push),
        .desc           (front_desc)
    );

    kfe_fifo #(
        .DEPTH (QUEUE_DEPTH)
    ) u_fifo (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (push),
        .wr_data   (front_desc),
        .pop       (pop),
        .rd_data   (head_desc),
        .full      (queue_full),
        .not_empty (queue_valid)
    );

    kfe_back u_back (
        .clk          (clk),
        .rst_n        (rst_n),
        .desc_valid   (queue_valid),
        .desc         (head_desc),
        .pop          (pop),
        .result_valid (result_valid),
        .result_stall (result_stall),
        .result       (result)
    );

endmodule

`default_nettype wire

// ===== hdl/kfe_checker.sv =====
// Port-level checks for the KISS frame encoder, bound to the top level.
`timescale 1ns / 1ps
`default_nettype none

module kfe_checker
    import kfe_pkg::*;
(
    input wire logic        clk,
    input wire logic        rst_n,
    input wire logic        result_valid,
    input wire logic        result_stall,
    input wire kfe_out_t    result
);

    // a stalled result transaction stays offered
    a_hold_valid: assert property (@(posedge clk) disable iff (!rst_n)
        result_valid && result_stall |=> result_valid)
        else $error("result dropped while stalled");

    // an error result carries a zero byte and ends the frame
    a_err_shape: assert property (@(posedge clk) disable iff (!rst_n)
        result_valid && result.overflow_error |->
            result.frame_done && result.end_of_output && (result.out_byte == 8'h00))
        else $error("malformed error result");

    // frame end is always the last result of its input transaction
    a_done_last: assert property (@(posedge clk) disable iff (!rst_n)
        result_valid && result.frame_done |-> result.end_of_output)
        else $error("frame done before end of output");

    // a clean frame end is the closing delimiter
    a_trailer: assert property (@(posedge clk) disable iff (!rst_n)
        result_valid && result.frame_done && !result.overflow_error |->
            result.out_byte == KISS_DELIM)
        else $error("frame closed without delimiter");

endmodule

bind kiss_frame_encoder kfe_checker u_kfe_checker (.*);

`default_nettype wire
